// ===== design/cau_pkg.sv =====
// cau_pkg: shared types, constants and helpers for the complex arithmetic unit.
// No dependencies.
package cau_pkg;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_SAT  = 2'd1,
        STAT_DIV0 = 2'd2
    } status_t;

    localparam int QW   = 17;      // quotient bits kept by the divider
    localparam int NUMW = 40;      // |N| * 256
    localparam int DENW = 32;      // br^2 + bi^2

    // Per-item control that travels with the divider stages.
    typedef struct packed {
        logic        is_div;
        logic        div0;
        logic        ovf_re;
        logic        ovf_im;
        logic        neg_re;
        logic        neg_im;
        logic [15:0] nd_re;
        logic [15:0] nd_im;
        logic        nd_sat;
    } meta_t;

    // Saturate a 33-bit signed value to 16 bits; bit 16 flags saturation.
    function automatic logic [16:0] sat16(input logic signed [32:0] v);
        logic [16:0] r;
        if (v > 33'sd32767) begin
            r = {1'b1, 16'h7fff};
        end else if (v < -33'sd32768) begin
            r = {1'b1, 16'h8000};
        end else begin
            r = {1'b0, v[15:0]};
        end
        return r;
    endfunction

    // Apply sign to a divider quotient and saturate; bit 16 flags saturation.
    function automatic logic [16:0] div_fix(input logic ovf, input logic neg,
                                            input logic [QW-1:0] q);
        logic [16:0] r;
        logic [15:0] mag;
        mag = q[15:0];
        if (!neg) begin
            if (ovf || q > 17'd32767) r = {1'b1, 16'h7fff};
            else                      r = {1'b0, mag};
        end else begin
            if (ovf || q > 17'd32768) r = {1'b1, 16'h8000};
            else                      r = {1'b0, 16'd0 - mag};
        end
        return r;
    endfunction

endpackage

// ===== design/complex_arith_unit.sv =====
// complex_arith_unit: pipelined complex add/sub/mul/div on signed Q8.8 operands.
// Depends on cau_pkg.
//
// Takes one request per cycle while the output side does not stall. Stage 1
// registers the operands, stage 2 forms the six 16x16 products, stage 3 forms
// sums, the add/sub/mul results and the divider setup, stages 4-20 run a
// restoring divider one quotient bit per stage (17 bits), and stage 21 applies
// sign and saturation. Divide truncates toward zero; a zero divisor gives zero
// parts and status 2. The whole pipeline holds while the output request is not
// taken.
module complex_arith_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_kind,
    input  logic signed [15:0]    s_a_real,
    input  logic signed [15:0]    s_a_imag,
    input  logic signed [15:0]    s_b_real,
    input  logic signed [15:0]    s_b_imag,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [15:0]    m_res_real,
    output logic signed [15:0]    m_res_imag,
    output logic [1:0]            m_status
);
    import cau_pkg::*;

    logic adv;

    // stage 1
    logic                v1_reg;
    kind_t               k1_reg;
    logic signed [15:0]  ar_reg, ai_reg, br_reg, bi_reg;
    // stage 2
    logic                v2_reg;
    kind_t               k2_reg;
    logic signed [16:0]  sre_reg, sim_reg, dre_reg, dim_reg;
    logic signed [31:0]  p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg, p_bb_reg, p_cc_reg;
    // divider chain, index 0 is stage 3
    logic                dv_reg  [QW+1];
    meta_t               meta_reg[QW+1];
    logic [NUMW-1:0]     rre_reg [QW+1];
    logic [NUMW-1:0]     rim_reg [QW+1];
    logic [QW-1:0]       qre_reg [QW+1];
    logic [QW-1:0]       qim_reg [QW+1];
    logic [DENW-1:0]     den_reg [QW+1];
    // output
    logic                m_valid_reg;
    logic [15:0]         ore_reg, oim_reg;
    status_t             ost_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // stage 3 combinational
    logic signed [32:0] mre, mim, nre, nim, mre_t, mim_t;
    logic [31:0]        abs_re, abs_im;
    logic [DENW-1:0]    den;
    logic [16:0]        sat_re, sat_im;
    meta_t              meta_next;

    always_comb begin
        mre   = 33'(p_rr_reg) - 33'(p_ii_reg);
        mim   = 33'(p_ri_reg) + 33'(p_ir_reg);
        nre   = 33'(p_rr_reg) + 33'(p_ii_reg);
        nim   = 33'(p_ir_reg) - 33'(p_ri_reg);
        mre_t = (mre + (mre[32] ? 33'sd255 : 33'sd0)) >>> 8;
        mim_t = (mim + (mim[32] ? 33'sd255 : 33'sd0)) >>> 8;
        den   = DENW'(p_bb_reg) + DENW'(p_cc_reg);
        abs_re = nre[32] ? 32'(-nre) : nre[31:0];
        abs_im = nim[32] ? 32'(-nim) : nim[31:0];
        case (k2_reg)
            KIND_ADD: begin
                sat_re = sat16(33'(sre_reg));
                sat_im = sat16(33'(sim_reg));
            end
            KIND_SUB: begin
                sat_re = sat16(33'(dre_reg));
                sat_im = sat16(33'(dim_reg));
            end
            default: begin
                sat_re = sat16(mre_t);
                sat_im = sat16(mim_t);
            end
        endcase
        meta_next.is_div = (k2_reg == KIND_DIV);
        meta_next.div0   = (den == '0);
        meta_next.ovf_re = ({9'd0, abs_re} >= {den, 9'd0});
        meta_next.ovf_im = ({9'd0, abs_im} >= {den, 9'd0});
        meta_next.neg_re = nre[32];
        meta_next.neg_im = nim[32];
        meta_next.nd_re  = sat_re[15:0];
        meta_next.nd_im  = sat_im[15:0];
        meta_next.nd_sat = sat_re[16] | sat_im[16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            dv_reg[0] <= 1'b0;
        end else if (adv) begin
            v1_reg    <= s_valid;
            v2_reg    <= v1_reg;
            dv_reg[0] <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            k1_reg <= kind_t'(s_kind);
            ar_reg <= s_a_real;
            ai_reg <= s_a_imag;
            br_reg <= s_b_real;
            bi_reg <= s_b_imag;

            k2_reg   <= k1_reg;
            sre_reg  <= 17'(ar_reg) + 17'(br_reg);
            sim_reg  <= 17'(ai_reg) + 17'(bi_reg);
            dre_reg  <= 17'(ar_reg) - 17'(br_reg);
            dim_reg  <= 17'(ai_reg) - 17'(bi_reg);
            p_rr_reg <= ar_reg * br_reg;
            p_ii_reg <= ai_reg * bi_reg;
            p_ir_reg <= ai_reg * br_reg;
            p_ri_reg <= ar_reg * bi_reg;
            p_bb_reg <= br_reg * br_reg;
            p_cc_reg <= bi_reg * bi_reg;

            meta_reg[0] <= meta_next;
            rre_reg[0]  <= {abs_re, 8'd0};
            rim_reg[0]  <= {abs_im, 8'd0};
            qre_reg[0]  <= '0;
            qim_reg[0]  <= '0;
            den_reg[0]  <= den;
        end
    end

    // restoring divider, stage i resolves quotient bit QW-1-i
    for (genvar i = 0; i < QW; i++) begin : g_div
        localparam int SH = QW - 1 - i;
        logic [NUMW+QW-1:0] trial;
        logic               ge_re, ge_im;
        assign trial = (NUMW+QW)'(den_reg[i]) << SH;
        assign ge_re = (NUMW+QW)'(rre_reg[i]) >= trial;
        assign ge_im = (NUMW+QW)'(rim_reg[i]) >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[i+1] <= 1'b0;
            end else if (adv) begin
                dv_reg[i+1] <= dv_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                meta_reg[i+1] <= meta_reg[i];
                den_reg[i+1]  <= den_reg[i];
                rre_reg[i+1]  <= ge_re ? NUMW'((NUMW+QW)'(rre_reg[i]) - trial) : rre_reg[i];
                rim_reg[i+1]  <= ge_im ? NUMW'((NUMW+QW)'(rim_reg[i]) - trial) : rim_reg[i];
                qre_reg[i+1]  <= qre_reg[i] | (QW'(ge_re) << SH);
                qim_reg[i+1]  <= qim_reg[i] | (QW'(ge_im) << SH);
            end
        end
    end

    // final stage
    meta_t       mf;
    logic [16:0] fre, fim;
    assign mf  = meta_reg[QW];
    assign fre = div_fix(mf.ovf_re, mf.neg_re, qre_reg[QW]);
    assign fim = div_fix(mf.ovf_im, mf.neg_im, qim_reg[QW]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (!mf.is_div) begin
                ore_reg <= mf.nd_re;
                oim_reg <= mf.nd_im;
                ost_reg <= mf.nd_sat ? STAT_SAT : STAT_OK;
            end else if (mf.div0) begin
                ore_reg <= '0;
                oim_reg <= '0;
                ost_reg <= STAT_DIV0;
            end else begin
                ore_reg <= fre[15:0];
                oim_reg <= fim[15:0];
                ost_reg <= (fre[16] | fim[16]) ? STAT_SAT : STAT_OK;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_res_real = ore_reg;
    assign m_res_imag = oim_reg;
    assign m_status   = ost_reg;

endmodule

// ===== design/cau_checker.sv =====
// cau_checker: port-level assertions for complex_arith_unit, bound to the top.
// Depends on cau_pkg.
module cau_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic [1:0]        s_kind,
    input logic              m_valid,
    input logic              m_ready,
    input logic [15:0]       m_res_real,
    input logic [15:0]       m_res_imag,
    input logic [1:0]        m_status
);
    import cau_pkg::*;

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STAT_OK || m_status == STAT_SAT || m_status == STAT_DIV0))
        else $error("bad status code");

    a_div0_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STAT_DIV0) |-> (m_res_real == '0 && m_res_imag == '0))
        else $error("divide by zero with nonzero result");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_res_real) && $stable(m_res_imag)
                                   && $stable(m_status)))
        else $error("stalled result changed");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_kind)))
        else $error("stalled request changed");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_kind     (s_kind),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_res_real (m_res_real),
    .m_res_imag (m_res_imag),
    .m_status   (m_status)
);

// ===== tb/tb_complex_arith_unit.sv =====
`timescale 1ns / 1ps
// tb_complex_arith_unit: checks add, subtract, multiply and divide results of complex_arith_unit
// against an in-bench predictor, with random idling on both channels. Depends on cau_pkg.
module tb_complex_arith_unit;
    import cau_pkg::*;

    typedef struct packed {
        logic signed [15:0] re;
        logic signed [15:0] im;
        status_t            st;
    } cplx_res_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_kind = KIND_ADD;
    logic signed [15:0] s_a_real = '0;
    logic signed [15:0] s_a_imag = '0;
    logic signed [15:0] s_b_real = '0;
    logic signed [15:0] s_b_imag = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_res_real;
    logic signed [15:0] m_res_imag;
    logic [1:0]         m_status;

    cplx_res_t expected_q[$];
    int        err_cnt = 0;
    bit        idle_on = 1'b1;
    int        hold_cycles = 0;

    complex_arith_unit DUT (.*);

    always #5 aclk = ~aclk;

    function automatic logic signed [15:0] clamp16(longint v, ref bit sat);
        if (v > 32767) begin
            sat = 1'b1;
            return 16'sh7fff;
        end
        if (v < -32768) begin
            sat = 1'b1;
            return -16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic cplx_res_t predict_cplx(kind_t k, longint ar, longint ai,
                                               longint br, longint bi);
        cplx_res_t r;
        longint    re, im, den;
        bit        sat;
        sat = 1'b0;
        case (k)
            KIND_ADD: begin re = ar + br; im = ai + bi; end
            KIND_SUB: begin re = ar - br; im = ai - bi; end
            KIND_MUL: begin
                re = (ar * br - ai * bi) / 256;
                im = (ar * bi + ai * br) / 256;
            end
            default: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.re = '0;
                    r.im = '0;
                    r.st = STAT_DIV0;
                    return r;
                end
                re = ((ar * br + ai * bi) * 256) / den;
                im = ((ai * br - ar * bi) * 256) / den;
            end
        endcase
        r.re = clamp16(re, sat);
        r.im = clamp16(im, sat);
        r.st = sat ? STAT_SAT : STAT_OK;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int exp_v);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
        err_cnt++;
    endtask

    // valid stays high after the last request; it drops when the sender idles
    task automatic send_request(kind_t k, logic [15:0] ar, logic [15:0] ai,
                                logic [15:0] br, logic [15:0] bi);
        while (idle_on && $urandom_range(99) < 16) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_kind   <= k;
        s_a_real <= ar;
        s_a_imag <= ai;
        s_b_real <= br;
        s_b_imag <= bi;
        expected_q.push_back(predict_cplx(k, $signed(ar), $signed(ai), $signed(br),
                                          $signed(bi)));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // receiver: random stalls, plus a forced hold when hold_cycles is set
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_ready <= !(idle_on && $urandom_range(99) < 16);
        end
    end

    always @(posedge aclk) begin
        cplx_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", m_res_real, 0);
            end else begin
                e = expected_q.pop_front();
                if (m_res_real !== e.re) report_mismatch("res_real", m_res_real, e.re);
                if (m_res_imag !== e.im) report_mismatch("res_imag", m_res_imag, e.im);
                if (m_status !== e.st) report_mismatch("status", m_status, e.st);
            end
        end
    end

    function automatic logic [15:0] rand_field();
        case ($urandom_range(5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(1024)) - 512);
            3: return 16'($signed($urandom_range(128)) - 64);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [15:0] ext[5];
        ext = '{16'h7fff, 16'h8000, 16'h0000, 16'h0100, 16'hffff};
        for (int k = 0; k < 4; k++) begin
            send_request(kind_t'(k), ext[k], ext[(k + 1) % 5], ext[(k + 3) % 5], ext[k + 1]);
            send_request(kind_t'(k), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
            send_request(kind_t'(k), 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
            send_request(kind_t'(k), 16'h0180, 16'hfe40, 16'h0200, 16'h0100);
        end
        send_request(KIND_DIV, 16'h0500, 16'hfb00, 16'h0000, 16'h0000);
        send_request(KIND_DIV, 16'h7fff, 16'h8000, 16'h0000, 16'h0001);
        send_request(KIND_DIV, 16'hff00, 16'h0000, 16'h0300, 16'h0000);
        send_request(KIND_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) idle_on = 1'b0;
            if (i == n / 2 + 150) idle_on = 1'b1;
            send_request(kind_t'($urandom_range(3)), rand_field(), rand_field(),
                         ($urandom_range(19) == 0) ? 16'h0000 : rand_field(),
                         ($urandom_range(19) == 0) ? 16'h0000 : rand_field());
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 80;
        for (int i = 0; i < 60; i++)
            send_request(kind_t'($urandom_range(3)), rand_field(), rand_field(),
                         rand_field(), rand_field());
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(770);
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
